// File: rtl/tdm_pkg.sv
`default_nettype none
package tdm_pkg;

  localparam logic [3:0] HEADER_BYTES = 4'd9;
  localparam logic [31:0] MAX_LEN_RESET = 32'd4087;

  typedef enum logic [2:0] {
    FN_RX_BYTE   = 3'd0,
    FN_OPEN      = 3'd1,
    FN_CLOSE     = 3'd2,
    FN_LINK_UP   = 3'd3,
    FN_LINK_DOWN = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    DEST_NONE     = 2'd0,
    DEST_DIR_DATA = 2'd1,
    DEST_UDP_DATA = 2'd2,
    DEST_UDP_CTRL = 2'd3
  } dest_e;

  typedef enum logic [3:0] {
    EV_NONE           = 4'd0,
    EV_TOO_LARGE      = 4'd1,
    EV_UNKNOWN_TYPE   = 4'd2,
    EV_BAD_PASSWORD   = 4'd3,
    EV_ACCESS_DENIED  = 4'd4,
    EV_OTHER_SYS      = 4'd5,
    EV_UNEXPECTED_OPEN = 4'd6,
    EV_STATUS_OK      = 4'd7,
    EV_STATUS_FAIL    = 4'd8,
    EV_CHAN_CLOSED    = 4'd9
  } event_e;

  typedef enum logic [1:0] {
    CH_CLOSED        = 2'd0,
    CH_CONNECTING    = 2'd1,
    CH_CONNECTED     = 2'd2,
    CH_DISCONNECTING = 2'd3
  } chan_e;

  // frame type byte
  localparam logic [7:0] FT_OPEN     = 8'd1;
  localparam logic [7:0] FT_DIR_DATA = 8'd2;
  localparam logic [7:0] FT_CLOSE    = 8'd3;
  localparam logic [7:0] FT_STATUS   = 8'd4;
  localparam logic [7:0] FT_UDP_DATA = 8'd5;
  localparam logic [7:0] FT_UDP_CTRL = 8'd6;
  localparam logic [7:0] FT_SYSTEM   = 8'd7;

  // system frame codes
  localparam logic [7:0] SYSCODE_BAD_PASS = 8'd1;
  localparam logic [7:0] SYSCODE_DENIED   = 8'd2;

  localparam logic [31:0] STATUS_LEN = 32'd4;
  localparam logic [31:0] SYSTEM_LEN = 32'd1;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] rx_byte;
  } tdm_in_t;

  typedef struct packed {
    logic [1:0]  dest;
    logic [7:0]  payload_byte;
    logic [31:0] remote_addr;
    logic        frame_last;
    logic [3:0]  event_res;
    logic [1:0]  channel_state;
    logic        link_is_up;
    logic [31:0] last_status;
  } tdm_res_t;

endpackage
`default_nettype wire

// File: rtl/tdm_in_if.sv
`default_nettype none
interface tdm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [7:0] rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink (input valid, input func, input rx_byte, output ready);
endinterface
`default_nettype wire

// File: rtl/tdm_out_if.sv
`default_nettype none
interface tdm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  dest;
  logic [7:0]  payload_byte;
  logic [31:0] remote_addr;
  logic        frame_last;
  logic [3:0]  event_res;
  logic [1:0]  channel_state;
  logic        link_is_up;
  logic [31:0] last_status;

  modport source (output valid, output dest, output payload_byte, output remote_addr,
                  output frame_last, output event_res, output channel_state,
                  output link_is_up, output last_status, input ready);
  modport sink (input valid, input dest, input payload_byte, input remote_addr,
                input frame_last, input event_res, input channel_state,
                input link_is_up, input last_status, output ready);
endinterface
`default_nettype wire

// File: rtl/typed_message_deframer.sv
// Pipeline: the input register loads when a transaction is accepted, and the
//   result register loads from it whenever the result stage is empty or drained.
// Throughput: one transaction per cycle, sustained. The input stalls only when
//   both stages are full and the result is not being taken.
// Reset (rst_ni low, asynchronous): link down, channel closed, all parser state
//   zero, max_len_q = 4087, both stages empty.
`default_nettype none
module typed_message_deframer import tdm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_data_i,
  tdm_in_if.sink           rx_i,
  tdm_out_if.source        res_o
);

  // ---------------------------------------------------------------------------
  // Pipeline control. Stage 1 holds the accepted transaction, stage 2 the
  // result. Stage 1 moves into stage 2 whenever stage 2 is empty or drained,
  // and all parser state updates at that same edge.
  // ---------------------------------------------------------------------------
  logic     s1_vld_q;
  tdm_in_t  s1_q;
  logic     res_vld_q;
  tdm_res_t res_q;
  logic     adv;
  logic     rx_rdy;
  logic     step;

  assign adv    = !res_vld_q || res_o.ready;
  assign rx_rdy = !s1_vld_q || adv;
  assign step   = s1_vld_q && adv;
  assign rx_i.ready = rx_rdy;

  // ---------------------------------------------------------------------------
  // Parser and channel state
  // ---------------------------------------------------------------------------
  logic [31:0] max_len_q;
  logic [3:0]  hdr_cnt_q, hdr_cnt_d;   // 0..8 header phase, 9 payload phase
  logic [7:0]  ftype_q, ftype_d;
  logic [31:0] addr_q, addr_d;
  logic [31:0] len_q, len_d;
  logic [31:0] left_q, left_d;
  logic [31:0] shift_q, shift_d;       // last four payload bytes, newest on top
  logic [7:0]  first_q, first_d;
  chan_e       chan_q, chan_d;
  logic        link_q, link_d;
  logic [31:0] status_q, status_d;

  dest_e       dest;
  event_e      ev;
  logic        last;
  logic        fin;
  logic [7:0]  b;
  logic [3:0]  cnt_inc;
  logic [31:0] left_dec;

  assign b        = s1_q.rx_byte;
  assign cnt_inc  = hdr_cnt_q + 4'd1;
  assign left_dec = left_q - {31'd0, (left_q != 32'd0)};

  always_comb begin
    hdr_cnt_d = hdr_cnt_q;
    ftype_d   = ftype_q;
    addr_d    = addr_q;
    len_d     = len_q;
    left_d    = left_q;
    shift_d   = shift_q;
    first_d   = first_q;
    chan_d    = chan_q;
    link_d    = link_q;
    status_d  = status_q;
    dest      = DEST_NONE;
    ev        = EV_NONE;
    last      = 1'b0;
    fin       = 1'b0;

    case (s1_q.func)
      FN_RX_BYTE: begin
        if (link_q) begin
          if (hdr_cnt_q < HEADER_BYTES) begin
            // header: type, address LSB first, length LSB first
            case (hdr_cnt_q)
              4'd0: begin
                ftype_d = b;
                addr_d  = 32'd0;
                len_d   = 32'd0;
              end
              4'd1: addr_d[7:0]   = addr_q[7:0]   | b;
              4'd2: addr_d[15:8]  = addr_q[15:8]  | b;
              4'd3: addr_d[23:16] = addr_q[23:16] | b;
              4'd4: addr_d[31:24] = addr_q[31:24] | b;
              4'd5: len_d[7:0]    = len_q[7:0]    | b;
              4'd6: len_d[15:8]   = len_q[15:8]   | b;
              4'd7: len_d[23:16]  = len_q[23:16]  | b;
              default: len_d[31:24] = len_q[31:24] | b;
            endcase
            hdr_cnt_d = cnt_inc;
            if (cnt_inc == HEADER_BYTES) begin
              if (len_d > max_len_q) begin
                link_d    = 1'b0;
                hdr_cnt_d = 4'd0;
                chan_d    = CH_CLOSED;
                ev        = EV_TOO_LARGE;
              end else begin
                left_d  = len_d;
                shift_d = 32'd0;
                first_d = 8'd0;
                if (len_d == 32'd0) begin
                  last = 1'b1;
                  fin  = 1'b1;
                end
              end
            end
          end else begin
            // payload byte
            if (left_q == len_q) begin
              first_d = b;
            end
            shift_d = {b, shift_q[31:8]};
            case (ftype_q)
              FT_DIR_DATA: dest = DEST_DIR_DATA;
              FT_UDP_DATA: dest = DEST_UDP_DATA;
              FT_UDP_CTRL: dest = DEST_UDP_CTRL;
              default:     dest = DEST_NONE;
            endcase
            left_d = left_dec;
            if (left_dec == 32'd0) begin
              last = 1'b1;
              fin  = 1'b1;
            end
          end
        end
      end
      FN_OPEN: begin
        if (link_q) begin
          chan_d = CH_CONNECTING;
        end
      end
      FN_CLOSE: chan_d = CH_CLOSED;
      FN_LINK_UP: begin
        link_d    = 1'b1;
        hdr_cnt_d = 4'd0;
        chan_d    = CH_CLOSED;
      end
      FN_LINK_DOWN: begin
        link_d    = 1'b0;
        hdr_cnt_d = 4'd0;
        chan_d    = CH_CLOSED;
      end
      default: ;
    endcase

    // frame completion: act on the frame type
    if (fin) begin
      hdr_cnt_d = 4'd0;
      case (ftype_d)
        FT_OPEN: ev = EV_UNEXPECTED_OPEN;
        FT_DIR_DATA, FT_UDP_DATA, FT_UDP_CTRL: ev = EV_NONE;
        FT_CLOSE: begin
          chan_d = CH_CLOSED;
          ev     = EV_CHAN_CLOSED;
        end
        FT_STATUS: begin
          if (len_d == STATUS_LEN) begin
            status_d = shift_d;
            if (chan_d == CH_CONNECTING) begin
              if (shift_d == 32'd0) begin
                chan_d = CH_CONNECTED;
                ev     = EV_STATUS_OK;
              end else begin
                chan_d = CH_CLOSED;
                ev     = EV_STATUS_FAIL;
              end
            end
          end
        end
        FT_SYSTEM: begin
          if (len_d == SYSTEM_LEN) begin
            if (first_d == SYSCODE_BAD_PASS) begin
              ev = EV_BAD_PASSWORD;
            end else if (first_d == SYSCODE_DENIED) begin
              ev = EV_ACCESS_DENIED;
            end else begin
              ev = EV_OTHER_SYS;
            end
            link_d = 1'b0;
            chan_d = CH_CLOSED;
          end
        end
        default: begin
          // unknown type drops the link
          link_d = 1'b0;
          chan_d = CH_CLOSED;
          ev     = EV_UNKNOWN_TYPE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RESET;
      s1_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
      hdr_cnt_q <= 4'd0;
      ftype_q   <= 8'd0;
      addr_q    <= 32'd0;
      len_q     <= 32'd0;
      left_q    <= 32'd0;
      shift_q   <= 32'd0;
      first_q   <= 8'd0;
      chan_q    <= CH_CLOSED;
      link_q    <= 1'b0;
      status_q  <= 32'd0;
    end else begin
      if (cfg_we_i) begin
        max_len_q <= cfg_data_i;
      end
      if (rx_rdy) begin
        s1_vld_q <= rx_i.valid;
      end
      if (adv) begin
        res_vld_q <= s1_vld_q;
      end
      if (step) begin
        hdr_cnt_q <= hdr_cnt_d;
        ftype_q   <= ftype_d;
        addr_q    <= addr_d;
        len_q     <= len_d;
        left_q    <= left_d;
        shift_q   <= shift_d;
        first_q   <= first_d;
        chan_q    <= chan_d;
        link_q    <= link_d;
        status_q  <= status_d;
      end
    end
  end

  // payload stages, no reset
  always_ff @(posedge clk_i) begin
    if (rx_rdy && rx_i.valid) begin
      s1_q.func    <= rx_i.func;
      s1_q.rx_byte <= rx_i.rx_byte;
    end
    if (step) begin
      res_q.dest          <= dest;
      res_q.payload_byte  <= (dest != DEST_NONE) ? b : 8'd0;
      res_q.remote_addr   <= addr_d;
      res_q.frame_last    <= last;
      res_q.event_res     <= ev;
      res_q.channel_state <= chan_d;
      res_q.link_is_up    <= link_d;
      res_q.last_status   <= status_d;
    end
  end

  assign res_o.valid         = res_vld_q;
  assign res_o.dest          = res_q.dest;
  assign res_o.payload_byte  = res_q.payload_byte;
  assign res_o.remote_addr   = res_q.remote_addr;
  assign res_o.frame_last    = res_q.frame_last;
  assign res_o.event_res     = res_q.event_res;
  assign res_o.channel_state = res_q.channel_state;
  assign res_o.link_is_up    = res_q.link_is_up;
  assign res_o.last_status   = res_q.last_status;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_hdr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_cnt_q <= HEADER_BYTES)
    else $error("header count out of range");

  a_down_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !link_q |-> (hdr_cnt_q == 4'd0 && chan_q == CH_CLOSED))
    else $error("parser or channel active while link down");

  a_payload_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hdr_cnt_q == HEADER_BYTES) |-> (left_q != 32'd0))
    else $error("payload phase with nothing left");

  a_no_disc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chan_q != CH_DISCONNECTING)
    else $error("channel entered disconnecting");

  a_ok_conn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && res_q.event_res == EV_STATUS_OK) |->
      (res_q.channel_state == CH_CONNECTED && res_q.frame_last))
    else $error("status ok without connected channel");

endmodule
`default_nettype wire
